@@ src/rms_level_meter_db_assert.svh @@
// Assertion macros used by the level meter RTL.
// Included by rlm_back, which checks its own logic; no other dependencies.
`ifndef RMS_LEVEL_METER_DB_ASSERT_SVH
`define RMS_LEVEL_METER_DB_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off while reset is asserted
`define RLM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rms_level_meter_db check failed");
// next-cycle implication
`define RLM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rms_level_meter_db check failed");
`else
`define RLM_ASSERT_NOW(label, clk, rstn, ante, cons)
`define RLM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ src/rlm_pkg.sv @@
// Types and constants for the RMS / dBFS level meter.
// No dependencies; imported by every module of the block.
`default_nettype none
package rlm_pkg;
    localparam int          SUM_W          = 35;
    localparam int          COUNT_BITS_DEF = 16;
    localparam int          SAMPLE_W       = 10;
    localparam logic [9:0]  MID_RESET      = 10'd512;
    localparam logic [18:0] DB_K           = 19'd394566;
    localparam logic [15:0] DB_LOWEST      = 16'h8000;
    localparam logic [28:0] LOG_FS_OFS     = 29'd285212672; // log2(512*256) in Q24
    localparam logic        OP_SAMPLE      = 1'b0;
    localparam logic        OP_REPORT      = 1'b1;

    typedef struct packed {
        logic       op;
        logic [9:0] sample;
    } in_t;

    typedef struct packed {
        logic [17:0]        rms_q8;
        logic signed [15:0] level_db_q8;
        logic [15:0]        sample_count;
        logic               empty_res;
        logic               overflowed;
    } out_t;
endpackage
`default_nettype wire

@@ src/rlm_front.sv @@
// Front end: midpoint register, sample accumulation, report job issue.
// Depends on rlm_pkg; feeds report jobs to rlm_queue.
`default_nettype none
module rlm_front
    import rlm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wen,
    input  wire logic [9:0]                    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire in_t                           s_data,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [SUM_W+COUNT_BITS:0]          q_data
);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_W:0]        SUM_MAX   = {1'b0, {SUM_W{1'b1}}};

    logic [9:0]            mid_reg;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  drop_reg, drop_next;
    logic [9:0]            delta;
    logic [19:0]           sq;
    logic [SUM_W:0]        sum_try;
    logic                  take;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign delta   = (s_data.sample >= mid_reg) ? s_data.sample - mid_reg
                                                : mid_reg - s_data.sample;
    assign sq      = delta * delta;
    assign sum_try = {1'b0, sum_reg} + {{(SUM_W-19){1'b0}}, sq};
    assign q_push  = take && (s_data.op == OP_REPORT);
    assign q_data  = {sum_reg, cnt_reg, drop_reg};

    always_comb begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (take) begin
            if (s_data.op == OP_REPORT) begin
                sum_next  = '0;
                cnt_next  = '0;
                drop_next = 1'b0;
            end else if (cnt_reg >= COUNT_MAX || sum_try > SUM_MAX) begin
                drop_next = 1'b1;
            end else begin
                sum_next = sum_try[SUM_W-1:0];
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg  <= MID_RESET;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                mid_reg <= cfg_wdata;
            end
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end
endmodule
`default_nettype wire

@@ src/rlm_queue.sv @@
// Two-entry job queue between front end and back end.
// Depends on rlm_pkg only for the default width; width is a parameter.
`default_nettype none
module rlm_queue
    import rlm_pkg::*;
#(
    parameter int W = SUM_W + COUNT_BITS_DEF + 1
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              avail,
    output logic [W-1:0]      pop_data
);
    logic [W-1:0] ent_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign avail    = (cnt_reg != 2'd0);
    assign pop_data = ent_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

@@ src/rlm_back.sv @@
// Back end: divide, square root, log2 and dB scaling for one report job.
// Depends on rlm_pkg and rms_level_meter_db_assert.svh; pops jobs from rlm_queue.
`default_nettype none
`include "rms_level_meter_db_assert.svh"
module rlm_back
    import rlm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         job_avail,
    input  wire logic [SUM_W+COUNT_BITS:0]    job_data,
    output logic                              job_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output out_t                              m_data
);
    localparam int DVD_W = SUM_W + 16;
    localparam int XW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_SQRT = 8'b0000_0100,
        ST_NORM = 8'b0000_1000,
        ST_LOG  = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_RND  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t                state_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  drop_reg, empty_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [DVD_W-1:0]      dvd_reg;
    logic [5:0]            it_reg;
    logic [51:0]           src_reg;
    logic [28:0]           srem_reg;
    logic [25:0]           root_reg;
    logic [30:0]           m_reg;
    logic [4:0]            e_reg;
    logic [23:0]           frac_reg;
    logic                  pos_reg;
    logic [47:0]           prod_reg;
    logic [17:0]           rms_reg;
    logic [15:0]           level_reg;
    logic                  out_valid_reg;
    out_t                  out_reg;

    logic [SUM_W-1:0]      job_sum;
    logic [COUNT_BITS-1:0] job_cnt;
    logic                  job_drop;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  dge;
    logic [DVD_W-1:0]      dvd_shift;
    logic [28:0]           s_sh, s_trial;
    logic                  sge;
    logic [25:0]           root_shift;
    logic [61:0]           sqv;
    logic                  lbit;
    logic [28:0]           lg, mag;
    logic [47:0]           rsum;
    logic [15:0]           rnd;
    logic [XW-1:0]         cnt_x;
    logic [15:0]           cnt_sat;
    logic                  out_free;

    assign {job_sum, job_cnt, job_drop} = job_data;

    assign rem_sh     = {rem_reg[COUNT_BITS-1:0], dvd_reg[DVD_W-1]};
    assign dge        = rem_sh >= {1'b0, cnt_reg};
    assign dvd_shift  = {dvd_reg[DVD_W-2:0], dge};
    assign s_sh       = {srem_reg[26:0], src_reg[51:50]};
    assign s_trial    = {1'b0, root_reg, 2'b01};
    assign sge        = s_sh >= s_trial;
    assign root_shift = {root_reg[24:0], sge};
    assign sqv        = m_reg * m_reg;
    assign lbit       = sqv[61];
    assign lg         = {e_reg, frac_reg};
    assign mag        = (lg >= LOG_FS_OFS) ? lg - LOG_FS_OFS : LOG_FS_OFS - lg;
    assign rsum       = prod_reg + 48'h0000_8000_0000;
    assign rnd        = rsum[47:32];
    assign cnt_x      = XW'(cnt_reg);
    assign cnt_sat    = (cnt_x > XW'(16'hFFFF)) ? 16'hFFFF : cnt_x[15:0];
    assign out_free   = !out_valid_reg || m_ready;
    assign job_pop    = (state_reg == ST_IDLE) && job_avail;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_avail) begin
                        cnt_reg   <= job_cnt;
                        drop_reg  <= job_drop;
                        empty_reg <= (job_cnt == '0);
                        dvd_reg   <= {job_sum, 16'h0000};
                        rem_reg   <= '0;
                        it_reg    <= 6'(DVD_W - 1);
                        rms_reg   <= '0;
                        level_reg <= DB_LOWEST;
                        state_reg <= (job_cnt == '0) ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= dge ? rem_sh - {1'b0, cnt_reg} : rem_sh;
                    dvd_reg <= dvd_shift;
                    it_reg  <= it_reg - 1'b1;
                    if (it_reg == '0) begin
                        src_reg   <= {1'b0, dvd_shift};
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        it_reg    <= 6'd25;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    srem_reg <= sge ? s_sh - s_trial : s_sh;
                    root_reg <= root_shift;
                    src_reg  <= {src_reg[49:0], 2'b00};
                    it_reg   <= it_reg - 1'b1;
                    if (it_reg == '0) begin
                        rms_reg   <= root_shift[17:0];
                        m_reg     <= {13'h0000, root_shift[17:0]};
                        e_reg     <= 5'd30;
                        state_reg <= (root_shift[17:0] == '0) ? ST_DONE : ST_NORM;
                    end
                end
                ST_NORM: begin
                    // left-justify the mantissa to Q30
                    if (m_reg[30]) begin
                        frac_reg  <= '0;
                        it_reg    <= 6'd23;
                        state_reg <= ST_LOG;
                    end else begin
                        m_reg <= {m_reg[29:0], 1'b0};
                        e_reg <= e_reg - 1'b1;
                    end
                end
                ST_LOG: begin
                    // square, then halve when the mantissa reaches two
                    m_reg    <= lbit ? sqv[61:31] : sqv[60:30];
                    frac_reg <= {frac_reg[22:0], lbit};
                    it_reg   <= it_reg - 1'b1;
                    if (it_reg == '0) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    pos_reg   <= (lg >= LOG_FS_OFS);
                    prod_reg  <= {19'd0, mag} * {29'd0, DB_K};
                    state_reg <= ST_RND;
                end
                ST_RND: begin
                    level_reg <= pos_reg ? rnd : 16'h0000 - rnd;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_reg.rms_q8       <= rms_reg;
                        out_reg.level_db_q8  <= level_reg;
                        out_reg.sample_count <= cnt_sat;
                        out_reg.empty_res    <= empty_reg;
                        out_reg.overflowed   <= drop_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `RLM_ASSERT_NOW(a_empty_result, aclk, aresetn, out_valid_reg && out_reg.empty_res, out_reg.rms_q8 == '0 && out_reg.level_db_q8 == DB_LOWEST && out_reg.sample_count == '0)
    `RLM_ASSERT_NOW(a_zero_rms_lowest, aclk, aresetn, out_valid_reg && out_reg.rms_q8 == '0, out_reg.level_db_q8 == DB_LOWEST)
    `RLM_ASSERT_NEXT(a_job_taken, aclk, aresetn, job_pop, state_reg != ST_IDLE)
endmodule
`default_nettype wire

@@ src/rms_level_meter_db.sv @@
// Top level of the RMS / dBFS level meter.
// Depends on rlm_pkg, rlm_front, rlm_queue and rlm_back.
`default_nettype none
// Sample words (op = 0) are centered on the midpoint register, squared and
// summed, so samples stream at one per clock while the job queue is not
// full. A report word (op = 1) snapshots the sum, count and drop flag into
// a two-entry job queue and clears them in the same cycle; the back end then
// works through the job serially: a job pickup, a restoring divide, a
// bit-pair square root, a mantissa normalize, a 24-step log2 by repeated
// squaring on one 31x31 multiplier, and dB scaling, rounding and output
// load (an empty report skips to the output load from pickup, a zero rms from
// the square root). The front stalls only when two reports are queued behind
// the one being computed. The result word sits in an output register, so the
// back end works on the next report while it waits, up to its output load.
module rms_level_meter_db
    import rlm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wen,
    input  wire logic [9:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data
);
    localparam int JOB_W = SUM_W + COUNT_BITS + 1;

    logic             q_push, q_full, q_pop, q_avail;
    logic [JOB_W-1:0] q_wdata, q_rdata;

    rlm_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    rlm_queue #(.W(JOB_W)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_rdata)
    );

    rlm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_avail (q_avail),
        .job_data  (q_rdata),
        .job_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );
endmodule
`default_nettype wire
